FILE: hdl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and codes of the nearest palette color search block.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int PALETTE_ENTRIES_DEF = 64;
    localparam int QUEUE_DEPTH_DEF     = 2;

    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int DIST_W  = 18;
    localparam int OIDX_W  = 6;

    // command codes on the input channel
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // status codes on the result channel
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_QUERY,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [COLOR_W-1:0] color;
    } cmd_item_t;

endpackage

FILE: hdl/nps_front.sv
// ----------------------------------------------------------------------------
// nps_front
// Input stage: takes items, decodes the command and holds one decoded item.
// ----------------------------------------------------------------------------
module nps_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              cmd,
    input  logic [nps_pkg::COLOR_W-1:0] color,
    output logic                    push_valid,
    input  logic                    push_ready,
    output nps_pkg::cmd_item_t      push_item
);
    import nps_pkg::*;

    logic      valid_reg;
    cmd_item_t item_reg;
    op_t       op_dec;
    logic      take;

    always_comb
    begin
        case (cmd)
            CMD_APPEND: op_dec = OP_APPEND;
            CMD_QUERY:  op_dec = OP_QUERY;
            CMD_CLEAR:  op_dec = OP_CLEAR;
            default:    op_dec = OP_NOP;
        endcase
    end

    assign in_stall   = valid_reg && !push_ready;
    assign take       = in_valid && !in_stall;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.op    <= op_dec;
            item_reg.color <= color;
        end
    end

endmodule

FILE: hdl/nps_queue.sv
// ----------------------------------------------------------------------------
// nps_queue
// Short FIFO of decoded items between the front and the search engine.
// ----------------------------------------------------------------------------
module nps_queue #(
    parameter int DEPTH = nps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  nps_pkg::cmd_item_t push_item,
    output logic               pop_valid,
    input  logic               pop,
    output nps_pkg::cmd_item_t pop_item
);
    import nps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_item_t          slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hdl/nps_back.sv
// ----------------------------------------------------------------------------
// nps_back
// Search engine: palette memory, append/clear handling and a pipelined
// nearest-color scan, one entry per cycle, with a result register.
// ----------------------------------------------------------------------------
module nps_back #(
    parameter int PALETTE_ENTRIES = nps_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  nps_pkg::cmd_item_t            q_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [nps_pkg::OIDX_W-1:0]    entry_index,
    output logic [nps_pkg::COLOR_W-1:0]   match_color,
    output logic [nps_pkg::DIST_W-1:0]    distance,
    output logic                          exact
);
    import nps_pkg::*;

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);
    localparam int EXT_W = (IDX_W > OIDX_W) ? IDX_W : OIDX_W;
    localparam int SQ_W  = 2 * CHAN_W;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;

    logic [COLOR_W-1:0]  palette_mem [PALETTE_ENTRIES];
    logic [COLOR_W-1:0]  rd_data_reg;

    // scan pipeline
    logic [COLOR_W-1:0]  query_color_reg;
    logic                issuing_reg;
    logic [IDX_W-1:0]    scan_idx_reg;
    logic                p1_valid_reg;
    logic                p1_last_reg;
    logic [IDX_W-1:0]    p1_idx_reg;
    logic                p2_valid_reg;
    logic                p2_last_reg;
    logic [IDX_W-1:0]    p2_idx_reg;
    logic [COLOR_W-1:0]  p2_color_reg;
    logic [SQ_W-1:0]     sq_r_reg;
    logic [SQ_W-1:0]     sq_g_reg;
    logic [SQ_W-1:0]     sq_b_reg;
    logic [DIST_W-1:0]   best_d_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [COLOR_W-1:0]  best_color_reg;

    // result register
    logic                out_valid_reg;
    logic [1:0]          status_reg;
    logic [OIDX_W-1:0]   entry_index_reg;
    logic [COLOR_W-1:0]  match_color_reg;
    logic [DIST_W-1:0]   distance_reg;
    logic                exact_reg;

    logic                out_free;
    logic                start;
    logic                room;
    logic                wr_en;
    logic                scan_last;
    logic [DIST_W-1:0]   p2_dist;
    logic                p2_better;
    logic [DIST_W-1:0]   fin_d;
    logic [IDX_W-1:0]    fin_idx;
    logic [COLOR_W-1:0]  fin_color;

    function automatic logic [OIDX_W-1:0] to_oidx(input logic [IDX_W-1:0] i);
        logic [EXT_W-1:0] w;
        w = EXT_W'(i);
        to_oidx = w[OIDX_W-1:0];
    endfunction

    function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        sq_diff = SQ_W'(d) * SQ_W'(d);
    endfunction

    assign out_free  = !out_valid_reg || !out_stall;
    assign start     = (state_reg == S_IDLE) && q_valid && out_free;
    assign q_pop     = start;
    assign room      = (count_reg < CNT_W'(PALETTE_ENTRIES));
    assign wr_en     = start && (q_item.op == OP_APPEND) && room;
    assign scan_last = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);

    assign p2_dist   = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    assign p2_better = (p2_dist < best_d_reg);
    assign fin_d     = p2_better ? p2_dist : best_d_reg;
    assign fin_idx   = p2_better ? p2_idx_reg : best_idx_reg;
    assign fin_color = p2_better ? p2_color_reg : best_color_reg;

    // palette storage, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            palette_mem[count_reg[IDX_W-1:0]] <= q_item.color;
        end
        if (issuing_reg)
        begin
            rd_data_reg <= palette_mem[scan_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            issuing_reg     <= 1'b0;
            scan_idx_reg    <= '0;
            p1_valid_reg    <= 1'b0;
            p1_last_reg     <= 1'b0;
            p1_idx_reg      <= '0;
            p2_valid_reg    <= 1'b0;
            p2_last_reg     <= 1'b0;
            p2_idx_reg      <= '0;
            p2_color_reg    <= '0;
            sq_r_reg        <= '0;
            sq_g_reg        <= '0;
            sq_b_reg        <= '0;
            query_color_reg <= '0;
            best_d_reg      <= '1;
            best_idx_reg    <= '0;
            best_color_reg  <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_OK;
            entry_index_reg <= '0;
            match_color_reg <= '0;
            distance_reg    <= '0;
            exact_reg       <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // pipeline: read -> squares -> sum and compare
            p1_valid_reg <= issuing_reg;
            p1_last_reg  <= issuing_reg && scan_last;
            p1_idx_reg   <= scan_idx_reg;
            p2_valid_reg <= p1_valid_reg;
            p2_last_reg  <= p1_last_reg;
            p2_idx_reg   <= p1_idx_reg;
            p2_color_reg <= rd_data_reg;
            sq_r_reg     <= sq_diff(query_color_reg[23:16], rd_data_reg[23:16]);
            sq_g_reg     <= sq_diff(query_color_reg[15:8], rd_data_reg[15:8]);
            sq_b_reg     <= sq_diff(query_color_reg[7:0], rd_data_reg[7:0]);

            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        out_valid_reg   <= 1'b1;
                        status_reg      <= ST_OK;
                        entry_index_reg <= '0;
                        match_color_reg <= '0;
                        distance_reg    <= '0;
                        exact_reg       <= 1'b0;
                        case (q_item.op)
                            OP_APPEND:
                            begin
                                if (room)
                                begin
                                    entry_index_reg <= to_oidx(count_reg[IDX_W-1:0]);
                                    match_color_reg <= q_item.color;
                                    count_reg       <= count_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    status_reg <= ST_FULL;
                                end
                            end
                            OP_QUERY:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= ST_EMPTY;
                                end
                                else
                                begin
                                    // result comes at the end of the scan
                                    out_valid_reg   <= 1'b0;
                                    state_reg       <= S_SCAN;
                                    query_color_reg <= q_item.color;
                                    issuing_reg     <= 1'b1;
                                    scan_idx_reg    <= '0;
                                    best_d_reg      <= '1;
                                    best_idx_reg    <= '0;
                                    best_color_reg  <= '0;
                                end
                            end
                            OP_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (issuing_reg)
                    begin
                        scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                        if (scan_last)
                        begin
                            issuing_reg <= 1'b0;
                        end
                    end
                    if (p2_valid_reg)
                    begin
                        best_d_reg     <= fin_d;
                        best_idx_reg   <= fin_idx;
                        best_color_reg <= fin_color;
                        if (p2_last_reg)
                        begin
                            // output slot was free at start and nothing else loads it
                            state_reg       <= S_IDLE;
                            out_valid_reg   <= 1'b1;
                            status_reg      <= ST_OK;
                            entry_index_reg <= to_oidx(fin_idx);
                            match_color_reg <= fin_color;
                            distance_reg    <= fin_d;
                            exact_reg       <= (fin_d == '0);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_index = entry_index_reg;
    assign match_color = match_color_reg;
    assign distance    = distance_reg;
    assign exact       = exact_reg;

endmodule

FILE: hdl/nearest_palette_color_search_top.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top
// Palette of packed RGB colors with append, clear and nearest-color query.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one item: cmd and color.
//   cmd 0 appends color to the palette, 1 queries the nearest stored color
//   (squared RGB distance, earliest entry wins ties), 2 clears the palette,
//   3 does nothing. Every item yields exactly one result item on the output
//   channel (out_valid/out_stall): status, entry_index, match_color,
//   distance, exact.
//   The scan reads the palette memory one entry per cycle through a single
//   read port, and the engine starts no new item until a query's scan ends;
//   append, clear and no-op need no scan.
//   A two-entry queue sits between the input stage and the engine, so the
//   input keeps taking items while a query scans, until the queue fills.
//   Reset empties the palette (entry count zero) and drops all items in
//   flight. A stalled result holds in the output register; the engine does
//   not start the next item until that register is free.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_top #(
    parameter int PALETTE_ENTRIES = nps_pkg::PALETTE_ENTRIES_DEF,
    parameter int QUEUE_DEPTH     = nps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    cmd,
    input  logic [nps_pkg::COLOR_W-1:0]   color,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [nps_pkg::OIDX_W-1:0]    entry_index,
    output logic [nps_pkg::COLOR_W-1:0]   match_color,
    output logic [nps_pkg::DIST_W-1:0]    distance,
    output logic                          exact
);
    import nps_pkg::*;

    // front -> queue
    logic      push_valid;
    logic      push_ready;
    cmd_item_t push_item;

    // queue -> engine
    logic      q_valid;
    logic      q_pop;
    cmd_item_t q_item;

    // input stage: decodes the command, holds one item
    nps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .color      (color),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    nps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_item)
    );

    // engine: palette memory, scan pipeline, result register
    nps_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .entry_index (entry_index),
        .match_color (match_color),
        .distance    (distance),
        .exact       (exact)
    );

endmodule

FILE: tb/tb_nearest_palette_color_search_top.sv
// ----------------------------------------------------------------------------
// tb_nearest_palette_color_search_top
// Self-checking bench for the palette append / clear / nearest-color query
// block. A behavioral palette in the bench predicts each result item that is
// not typed in by hand. A short directed table covers the corners, then
// random append/query runs follow, with random idle and stall cycles on both channels.
// ----------------------------------------------------------------------------
module tb_nearest_palette_color_search_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nps_pkg::*;

    // cmd code 3 is unused by the block: no state change, all-zero result
    localparam logic [1:0] CMD_IDLE = 2'd3;

    localparam int PAL_DEPTH    = PALETTE_ENTRIES_DEF;
    localparam int N_ITEMS      = 1550;
    // drain time covers a full-palette query, with margin for a stall
    localparam int DRAIN_CYCLES = PAL_DEPTH + 20;
    localparam int N_DIRECTED   = 20;

    typedef struct packed {
        logic [1:0]         status;
        logic [OIDX_W-1:0]  index;
        logic [COLOR_W-1:0] color;
        logic [DIST_W-1:0]  sq_dist;
        logic               exact;
    } palette_result_t;

    // One row of the directed table. When has_res is set, res is the result
    // typed in by hand; otherwise the predictor supplies it.
    typedef struct packed {
        logic [1:0]         cmd;
        logic [COLOR_W-1:0] color;
        logic               has_res;
        palette_result_t    res;
    } stim_row_t;

    localparam palette_result_t ZERO_RESULT = '0;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         cmd;
    logic [COLOR_W-1:0] color;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic [OIDX_W-1:0]  entry_index;
    logic [COLOR_W-1:0] match_color;
    logic [DIST_W-1:0]  distance;
    logic               exact;

    // ------------------------------------------------------------------------
    // Predictor state: a copy of the palette and its fill count, updated at
    // the moment each input item is accepted.
    // ------------------------------------------------------------------------
    logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];
    int                 pal_count;
    palette_result_t    pending_results [$];
    stim_row_t          directed_rows [N_DIRECTED];
    int                 fail_count;
    int                 items_sent;
    // set for stretches where neither side inserts idle or stall cycles
    bit                 calm;

    nearest_palette_color_search_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .color       (color),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .entry_index (entry_index),
        .match_color (match_color),
        .distance    (distance),
        .exact       (exact)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop. The slowest legal run is roughly 1550 items, each at worst a
    // full-palette scan plus the worst idle and stall, about 1.5 ms.
    initial
    begin
        #10ms;
        $display("nearest_palette_color_search_top: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int chan_sq(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
        int d;
        d = int'(a) - int'(b);
        return d * d;
    endfunction

    function automatic int color_distance(input logic [COLOR_W-1:0] x,
                                          input logic [COLOR_W-1:0] y);
        return chan_sq(x[23:16], y[23:16]) + chan_sq(x[15:8], y[15:8])
             + chan_sq(x[7:0], y[7:0]);
    endfunction

    // Applies one command to the palette copy and returns the result item.
    function automatic palette_result_t apply_palette_cmd(input logic [1:0] c,
                                                          input logic [COLOR_W-1:0] col);
        palette_result_t r;
        int best_d;
        int d;
        int i;
        r = ZERO_RESULT;
        case (c)
            CMD_APPEND:
            begin
                if (pal_count < PAL_DEPTH)
                begin
                    pal_mem[pal_count] = col;
                    r.index = OIDX_W'(pal_count);
                    r.color = col;
                    pal_count++;
                end
                else
                    r.status = ST_FULL;
            end
            CMD_QUERY:
            begin
                if (pal_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    // strict less-than: the earliest entry keeps a tie
                    best_d = color_distance(col, pal_mem[0]);
                    r.color = pal_mem[0];
                    for (i = 1; i < pal_count; i++)
                    begin
                        d = color_distance(col, pal_mem[i]);
                        if (d < best_d)
                        begin
                            best_d = d;
                            r.index = OIDX_W'(i);
                            r.color = pal_mem[i];
                        end
                    end
                    r.sq_dist = DIST_W'(best_d);
                    r.exact   = (r.color == col);
                end
            end
            CMD_CLEAR:
                pal_count = 0;
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------
    function automatic int pick_wait();
        if (calm)
            return 0;
        return $urandom_range(0, 4);
    endfunction

    // small per-channel offset, clamped at 0 and 255
    function automatic logic [COLOR_W-1:0] nudge_color(input logic [COLOR_W-1:0] col);
        logic [COLOR_W-1:0] r;
        int v;
        int k;
        for (k = 0; k < 3; k++)
        begin
            v = int'(col[k*8 +: 8]) + int'($urandom_range(0, 8)) - 4;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            r[k*8 +: 8] = CHAN_W'(v);
        end
        return r;
    endfunction

    function automatic logic [COLOR_W-1:0] stored_color();
        return pal_mem[$urandom_range(0, pal_count - 1)];
    endfunction

    // Appends: mostly random, some duplicates and near neighbors so that
    // ties and repeated colors show up in the scan.
    function automatic logic [COLOR_W-1:0] append_color();
        if (pal_count == 0 || pal_count >= PAL_DEPTH)
            return COLOR_W'($urandom);
        case ($urandom_range(0, 7))
            0:       return stored_color();
            1, 2:    return nudge_color(stored_color());
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    function automatic logic [COLOR_W-1:0] query_color();
        int k;
        if (pal_count == 0)
            return COLOR_W'($urandom);
        case ($urandom_range(0, 5))
            0, 1: return COLOR_W'($urandom);
            2:    return stored_color();
            3, 4: return nudge_color(stored_color());
            default:
            begin
                // pure primaries, black and white
                k = $urandom_range(0, 4);
                if (k < 3)
                    return COLOR_W'(24'hFF << (8 * k));
                return (k == 3) ? '0 : '1;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Valid stays high from one item to the next when no idle
    // cycle is drawn, so it is never dropped and raised in one time step.
    // The expected result is computed at the accepting edge.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] c, input logic [COLOR_W-1:0] col,
                             input bit has_res = 1'b0,
                             input palette_result_t fixed_res = ZERO_RESULT);
        int gap;
        palette_result_t want;
        gap = pick_wait();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        color    <= col;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = apply_palette_cmd(c, col);
        pending_results.push_back(has_res ? fixed_res : want);
        items_sent++;
    endtask

    // Sender goes quiet until every result item in flight has come back.
    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall before each result item.
    // ------------------------------------------------------------------------
    initial
    begin : result_stall
        int k;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            k = pick_wait();
            @(negedge clk);
            if (k > 0)
            begin
                out_stall <= 1'b1;
                repeat (k) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall))
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: in-order compare against the oldest expectation.
    // ------------------------------------------------------------------------
    task automatic check_result();
        palette_result_t want;
        if (pending_results.size() == 0)
        begin
            $error("result item with nothing pending: status %0d entry_index %0d",
                   status, entry_index);
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        if (status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
        end
        if (entry_index !== want.index)
        begin
            $error("entry_index: expected %0d, got %0d", want.index, entry_index);
            fail_count++;
        end
        if (match_color !== want.color)
        begin
            $error("match_color: expected %06h, got %06h", want.color, match_color);
            fail_count++;
        end
        if (distance !== want.sq_dist)
        begin
            $error("distance: expected %0d, got %0d", want.sq_dist, distance);
            fail_count++;
        end
        if (exact !== want.exact)
        begin
            $error("exact: expected %0d, got %0d", want.exact, exact);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_result();
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int seq;
        int n_app;
        int n_qry;
        int i;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cmd        = CMD_IDLE;
        color      = '0;
        calm       = 1'b0;
        fail_count = 0;
        items_sent = 0;
        pal_count  = 0;
        for (i = 0; i < PAL_DEPTH; i++)
            pal_mem[i] = '0;

        // Directed corners. Hand-typed results where they are obvious;
        // nearest-neighbor rows go through the predictor.
        directed_rows = '{
            // query before anything is stored -> empty status
            '{CMD_QUERY,  24'h123456, 1'b1, '{ST_EMPTY, 6'd0, 24'h0, 18'd0, 1'b0}},
            // unused command leaves state alone
            '{CMD_IDLE,   24'hFFFFFF, 1'b1, ZERO_RESULT},
            '{CMD_APPEND, 24'h000000, 1'b1, '{ST_OK, 6'd0, 24'h000000, 18'd0, 1'b0}},
            '{CMD_APPEND, 24'hFFFFFF, 1'b1, '{ST_OK, 6'd1, 24'hFFFFFF, 18'd0, 1'b0}},
            '{CMD_QUERY,  24'hFFFFFF, 1'b1, '{ST_OK, 6'd1, 24'hFFFFFF, 18'd0, 1'b1}},
            '{CMD_QUERY,  24'h000000, 1'b1, '{ST_OK, 6'd0, 24'h000000, 18'd0, 1'b1}},
            '{CMD_QUERY,  24'h808080, 1'b0, ZERO_RESULT},
            '{CMD_APPEND, 24'h020000, 1'b0, ZERO_RESULT},
            // equidistant from entries 0 and 2: earlier entry wins
            '{CMD_QUERY,  24'h010000, 1'b0, ZERO_RESULT},
            '{CMD_APPEND, 24'h00FF00, 1'b0, ZERO_RESULT},
            '{CMD_APPEND, 24'h00FF00, 1'b0, ZERO_RESULT},
            // duplicate color: first copy is reported
            '{CMD_QUERY,  24'h00FF00, 1'b0, ZERO_RESULT},
            '{CMD_QUERY,  24'hFF0000, 1'b0, ZERO_RESULT},
            '{CMD_QUERY,  24'h0000FF, 1'b0, ZERO_RESULT},
            '{CMD_IDLE,   24'h000000, 1'b1, ZERO_RESULT},
            '{CMD_CLEAR,  24'hABCDEF, 1'b1, ZERO_RESULT},
            '{CMD_QUERY,  24'h000000, 1'b1, '{ST_EMPTY, 6'd0, 24'h0, 18'd0, 1'b0}},
            '{CMD_APPEND, 24'h000000, 1'b1, '{ST_OK, 6'd0, 24'h000000, 18'd0, 1'b0}},
            // largest possible distance: white against black
            '{CMD_QUERY,  24'hFFFFFF, 1'b1, '{ST_OK, 6'd0, 24'h000000, 18'd195075, 1'b0}},
            '{CMD_CLEAR,  24'h000000, 1'b1, ZERO_RESULT}
        };

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++)
            send_item(directed_rows[i].cmd, directed_rows[i].color,
                      directed_rows[i].has_res, directed_rows[i].res);

        // Random part: an optional clear, a run of appends, then a burst of queries.
        // Run 0 overfills the palette to hit the full status; run 1 starts
        // with the sender waiting for every result to drain.
        seq = 0;
        while (items_sent < N_ITEMS)
        begin
            calm = ($urandom_range(0, 3) == 0);
            if (seq == 1 || $urandom_range(0, 7) == 0)
                hold_until_drained();
            if (seq == 0 || $urandom_range(0, 3) != 0)
                send_item(CMD_CLEAR, COLOR_W'($urandom));

            if (seq == 0)
                n_app = PAL_DEPTH + 3;
            else if ($urandom_range(0, 4) == 0)
                n_app = $urandom_range(1, PAL_DEPTH + 4);
            else
                n_app = $urandom_range(1, 12);
            for (i = 0; i < n_app; i++)
                send_item(CMD_APPEND, append_color());

            n_qry = $urandom_range(2, 14);
            for (i = 0; i < n_qry; i++)
                send_item(CMD_QUERY, query_color());

            // stray command of any code, including the unused one
            if ($urandom_range(0, 5) == 0)
                send_item(2'($urandom_range(0, 3)), COLOR_W'($urandom));
            seq++;
        end

        // wait out every pending result, then a scan's worth of cycles for
        // anything extra the block might still push out
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("nearest_palette_color_search_top: match");
        else
            $display("nearest_palette_color_search_top: mismatch");
        $finish;
    end

endmodule
